// ----- rtl/ipbl_pkg.sv -----
// ----------------------------------------------------------------------------
// ipbl_pkg: shared definitions of the IP range blocklist
// Operation and status codes, field widths and the default table depth.
// ----------------------------------------------------------------------------
`default_nettype none

package ipbl_pkg;

  localparam int unsigned DefaultDepth = 1024;

  localparam int unsigned AddrW  = 32;
  localparam int unsigned EntryW = 2 * AddrW;
  localparam int unsigned LiveW  = 11;
  localparam int unsigned OpW    = 2;
  localparam int unsigned StatW  = 2;

  localparam logic [OpW-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OpW-1:0] OP_LOAD   = 2'd1;
  localparam logic [OpW-1:0] OP_COMMIT = 2'd2;
  localparam logic [OpW-1:0] OP_LOOKUP = 2'd3;

  localparam logic [StatW-1:0] ST_OK       = 2'd0;
  localparam logic [StatW-1:0] ST_INVERTED = 2'd1;
  localparam logic [StatW-1:0] ST_FULL     = 2'd2;

  localparam logic [AddrW-1:0] ALL_ONES = 32'hFFFF_FFFF;

endpackage

`default_nettype wire

// ----- rtl/ipbl_ram.sv -----
// ----------------------------------------------------------------------------
// ipbl_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module ipbl_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/ip_range_blocklist_top.sv -----
// ----------------------------------------------------------------------------
// ip_range_blocklist_top: IPv4 range blocklist with coalescing commit
// Pending ranges are sorted in place and merged into the live table; lookups
// run a binary search over the live table.
// ----------------------------------------------------------------------------
// Usage: one word on the in_ channel carries an operation in in_tuser and the
// range and lookup address in in_tdata; every word returns exactly one word
// on the out_ channel. Clear and load pass from accept through S_EMIT to the
// output register. A lookup runs a binary search over the live ranges; each
// step issues a live RAM read and compares the registered read data.
// A commit sorts the pending RAM in place by insertion sort and then merges
// it into the live RAM; the sort does the least work for sorted input and
// the most for reversed input.
// One word is worked on at a time. The result waits in an output register,
// so a stalled receiver holds only that word; a new word is still accepted
// and its result waits until the output register is free.
// Reset empties both tables (counts only, no RAM clearing pass).
// ----------------------------------------------------------------------------
`default_nettype none

module ip_range_blocklist_top #(
  parameter int unsigned TABLE_DEPTH = ipbl_pkg::DefaultDepth
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // in_tdata: range_start[31:0], range_end[63:32], lookup_address[95:64]
  input  wire logic [95:0] in_tdata,
  // in_tuser: operation[1:0]
  input  wire logic [1:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // out_tdata: blocked[0], live_entries[11:1], status[13:12], zero[15:14]
  output logic      [15:0] out_tdata
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned EW = ipbl_pkg::EntryW;
  localparam int unsigned XW = ipbl_pkg::AddrW;
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_EMIT     = 4'd1;
  localparam logic [3:0] S_SORT_KEY = 4'd2;
  localparam logic [3:0] S_SORT_CMP = 4'd3;
  localparam logic [3:0] S_SORT_PUT = 4'd4;
  localparam logic [3:0] S_MRG_INIT = 4'd5;
  localparam logic [3:0] S_MRG_FST  = 4'd6;
  localparam logic [3:0] S_MRG_STEP = 4'd7;
  localparam logic [3:0] S_MRG_FLSH = 4'd8;
  localparam logic [3:0] S_LK_ISSUE = 4'd9;
  localparam logic [3:0] S_LK_CMP   = 4'd10;

  logic [3:0]    state_r, state_nxt;
  logic [CW-1:0] pend_cnt_r, pend_cnt_nxt;
  logic [CW-1:0] live_cnt_r, live_cnt_nxt;
  logic [CW-1:0] i_r, i_nxt;
  logic [CW-1:0] j_r, j_nxt;
  logic [CW-1:0] lo_r, lo_nxt;
  logic [CW-1:0] hi_r, hi_nxt;
  logic [CW-1:0] mid_r, mid_nxt;
  logic [EW-1:0] key_r, key_nxt;
  logic [XW-1:0] addr_r, addr_nxt;
  logic          found_r, found_nxt;
  logic [XW-1:0] cand_r, cand_nxt;
  logic          res_blk_r, res_blk_nxt;
  logic [1:0]    res_st_r, res_st_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [15:0]   out_data_r, out_data_nxt;

  logic          p_we, l_we;
  logic [AW-1:0] p_waddr, p_raddr, l_waddr, l_raddr;
  logic [EW-1:0] p_wdata, p_rdata, l_wdata, l_rdata;

  logic [XW-1:0] rs, re, cur_s, cur_e;
  logic [CW-1:0] mid_calc;
  logic          joins;

  ipbl_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_pend (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
    .raddr(p_raddr), .rdata(p_rdata)
  );

  ipbl_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_live (
    .clk(clk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
    .raddr(l_raddr), .rdata(l_rdata)
  );

  // Entries are {start, end}, so one unsigned compare orders by start, then end.
  // key_r doubles as the open merged range during the merge pass.
  assign rs    = in_tdata[31:0];
  assign re    = in_tdata[63:32];
  assign cur_s = key_r[EW-1:XW];
  assign cur_e = key_r[XW-1:0];
  assign joins = (p_rdata[EW-1:XW] <= cur_e) ||
                 ((cur_e != ipbl_pkg::ALL_ONES) && (p_rdata[EW-1:XW] == cur_e + 32'd1));
  assign mid_calc = lo_r + ((hi_r - lo_r) >> 1);

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    pend_cnt_nxt  = pend_cnt_r;
    live_cnt_nxt  = live_cnt_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    key_nxt       = key_r;
    addr_nxt      = addr_r;
    found_nxt     = found_r;
    cand_nxt      = cand_r;
    res_blk_nxt   = res_blk_r;
    res_st_nxt    = res_st_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    p_we    = 1'b0;
    p_waddr = pend_cnt_r[AW-1:0];
    p_wdata = {rs, re};
    p_raddr = '0;
    l_we    = 1'b0;
    l_waddr = live_cnt_r[AW-1:0];
    l_wdata = key_r;
    l_raddr = mid_calc[AW-1:0];

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          res_blk_nxt = 1'b0;
          res_st_nxt  = ipbl_pkg::ST_OK;
          state_nxt   = S_EMIT;
          case (in_tuser)
            ipbl_pkg::OP_CLEAR: begin
              pend_cnt_nxt = '0;
            end
            ipbl_pkg::OP_LOAD: begin
              if (rs > re) begin
                res_st_nxt = ipbl_pkg::ST_INVERTED;
              end else if (pend_cnt_r >= DEPTH_C) begin
                res_st_nxt = ipbl_pkg::ST_FULL;
              end else begin
                p_we         = 1'b1;
                pend_cnt_nxt = pend_cnt_r + 1'b1;
              end
            end
            ipbl_pkg::OP_COMMIT: begin
              if (pend_cnt_r == '0) begin
                live_cnt_nxt = '0;
              end else if (pend_cnt_r == CW'(1)) begin
                state_nxt = S_MRG_INIT;
              end else begin
                i_nxt     = CW'(1);
                p_raddr   = AW'(1);
                state_nxt = S_SORT_KEY;
              end
            end
            default: begin
              addr_nxt  = in_tdata[95:64];
              found_nxt = 1'b0;
              lo_nxt    = '0;
              hi_nxt    = live_cnt_r;
              if (live_cnt_r != '0) begin
                state_nxt = S_LK_ISSUE;
              end
            end
          endcase
        end
      end
      S_SORT_KEY: begin
        key_nxt   = p_rdata;
        j_nxt     = i_r;
        p_raddr   = AW'(i_r - 1'b1);
        state_nxt = S_SORT_CMP;
      end
      S_SORT_CMP: begin
        // p_rdata is entry j-1; shift it up while the key sorts before it.
        if (key_r < p_rdata) begin
          p_we    = 1'b1;
          p_waddr = j_r[AW-1:0];
          p_wdata = p_rdata;
          j_nxt   = j_r - 1'b1;
          if (j_r == CW'(1)) begin
            state_nxt = S_SORT_PUT;
          end else begin
            p_raddr = AW'(j_r - CW'(2));
          end
        end else begin
          state_nxt = S_SORT_PUT;
        end
      end
      S_SORT_PUT: begin
        p_we    = 1'b1;
        p_waddr = j_r[AW-1:0];
        p_wdata = key_r;
        i_nxt   = i_r + 1'b1;
        if (i_r + 1'b1 == pend_cnt_r) begin
          state_nxt = S_MRG_INIT;
        end else begin
          p_raddr   = AW'(i_r + 1'b1);
          state_nxt = S_SORT_KEY;
        end
      end
      S_MRG_INIT: begin
        p_raddr      = '0;
        live_cnt_nxt = '0;
        state_nxt    = S_MRG_FST;
      end
      S_MRG_FST: begin
        key_nxt = p_rdata;
        i_nxt   = CW'(1);
        if (pend_cnt_r == CW'(1)) begin
          state_nxt = S_MRG_FLSH;
        end else begin
          p_raddr   = AW'(1);
          state_nxt = S_MRG_STEP;
        end
      end
      S_MRG_STEP: begin
        if (joins) begin
          if (p_rdata[XW-1:0] > cur_e) begin
            key_nxt = {cur_s, p_rdata[XW-1:0]};
          end
        end else begin
          l_we         = 1'b1;
          live_cnt_nxt = live_cnt_r + 1'b1;
          key_nxt      = p_rdata;
        end
        i_nxt = i_r + 1'b1;
        if (i_r + 1'b1 == pend_cnt_r) begin
          state_nxt = S_MRG_FLSH;
        end else begin
          p_raddr = AW'(i_r + 1'b1);
        end
      end
      S_MRG_FLSH: begin
        l_we         = 1'b1;
        live_cnt_nxt = live_cnt_r + 1'b1;
        pend_cnt_nxt = '0;
        state_nxt    = S_EMIT;
      end
      S_LK_ISSUE: begin
        mid_nxt   = mid_calc;
        state_nxt = S_LK_CMP;
      end
      S_LK_CMP: begin
        // The last probe that went right is the range at lo-1 at the end.
        if (addr_r < l_rdata[EW-1:XW]) begin
          hi_nxt = mid_r;
          if (lo_r >= mid_r) begin
            state_nxt = S_EMIT;
          end else begin
            state_nxt = S_LK_ISSUE;
          end
        end else begin
          lo_nxt    = mid_r + 1'b1;
          found_nxt = 1'b1;
          cand_nxt  = l_rdata[XW-1:0];
          if (mid_r + 1'b1 >= hi_r) begin
            state_nxt = S_EMIT;
          end else begin
            state_nxt = S_LK_ISSUE;
          end
        end
        if (state_nxt == S_EMIT) begin
          res_blk_nxt = (addr_r < l_rdata[EW-1:XW]) ? (found_r && (addr_r <= cand_r))
                                                    : (addr_r <= l_rdata[XW-1:0]);
        end
      end
      S_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {2'b00, res_st_r, ipbl_pkg::LiveW'(live_cnt_r), res_blk_r};
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pend_cnt_r  <= '0;
      live_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_cnt_r  <= pend_cnt_nxt;
      live_cnt_r  <= live_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    mid_r      <= mid_nxt;
    key_r      <= key_nxt;
    addr_r     <= addr_nxt;
    found_r    <= found_nxt;
    cand_r     <= cand_nxt;
    res_blk_r  <= res_blk_nxt;
    res_st_r   <= res_st_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

`default_nettype wire
